@@ hdl/mhe_pkg.sv @@
// shared types and constants for the max-heap extract block
`timescale 1ns / 1ps

package mhe_pkg;

  localparam int CAPACITY_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH     = 32;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_WAIT,
    S_SIFT
  } state_t;

  typedef struct packed {
    mode_t                         mode;
    logic signed [FIELD_WIDTH-1:0] load_value;
  } request_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] max_value;
    status_t                       status;
  } response_t;

endpackage

@@ hdl/max_heap_extract.sv @@
// top level: binary max-heap with load and extract-max over a chain of level cells
//
//   channel    signals                      direction  transaction
//   request    start, busy, request         in         start high while busy low
//   response   done, response               out        done high for one cycle
//
// a load's response strobes on the cycle after start.
// an extract strobes its response on the cycle after start; when more than one
// entry remains it then holds busy while the sift walks down one cell per level,
// each level a ram read stage and a compare stage.
// reset empties the heap; stored values are undefined until written.
// the receiver cannot stall, so busy comes from the sift alone.
`timescale 1ns / 1ps

module max_heap_extract import mhe_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  request_t  request,
  output logic      busy,
  output logic      done,
  output response_t response
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW;
  localparam int D  = CW - 1;
  localparam int LW = $clog2(CW + 1);
  localparam int VW = VALUE_WIDTH;

  state_t               state;
  state_t               state_next;
  logic [CW-1:0]        count;
  logic [LW-1:0]        tail_lvl;
  logic [PW-1:0]        tail_pos;
  logic [LW-1:0]        tail_lvl_next;
  logic [PW-1:0]        tail_pos_next;
  logic [PW:0]          lvl_size;
  logic [PW:0]          pos_up;
  logic signed [VW-1:0] root;
  logic signed [VW-1:0] ld_value;
  logic signed [VW-1:0] fetched;
  logic                 accept;
  logic                 load_en;
  logic                 full;
  logic                 inj_valid;
  logic signed [VW-1:0] inj_value;
  logic                 sift_done;

  wire                 tok_v   [1:D];
  wire [PW-1:0]        tok_pos [1:D];
  wire signed [VW-1:0] tok_val [1:D];
  wire                 up_v    [1:D];
  wire [PW-1:0]        up_pos  [1:D];
  wire signed [VW-1:0] up_val  [1:D];
  wire signed [VW-1:0] fetch_val [1:D];
  wire [D:1]           settle;

  assign busy     = (state != S_IDLE);
  assign accept   = start & ~busy;
  assign full     = (count == CW'(CAPACITY));
  assign load_en  = accept && (request.mode == MODE_LOAD) && !full;
  assign ld_value = VW'(request.load_value);

  // chain of level cells
  for (genvar k = 1; k <= D; k++) begin : g_level
    wire                 tin_v;
    wire [PW-1:0]        tin_pos;
    wire signed [VW-1:0] tin_val;
    wire                 cw_v;
    wire [PW-1:0]        cw_pos;
    wire signed [VW-1:0] cw_val;
    wire                 ld_hit;

    if (k == 1) begin : g_first
      assign tin_v   = inj_valid;
      assign tin_pos = '0;
      assign tin_val = inj_value;
    end else begin : g_inner
      assign tin_v   = tok_v[k-1];
      assign tin_pos = tok_pos[k-1];
      assign tin_val = tok_val[k-1];
    end

    // child write-back, or the tail of the chain parking the token
    if (k == D) begin : g_tail
      assign cw_v   = tok_v[k];
      assign cw_pos = tok_pos[k];
      assign cw_val = tok_val[k];
    end else begin : g_body
      assign cw_v   = up_v[k+1];
      assign cw_pos = up_pos[k+1];
      assign cw_val = up_val[k+1];
    end

    assign ld_hit = load_en && (tail_lvl == LW'(k));

    mhe_cell #(
      .LEVEL       (k),
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .count         (count),
      .tok_in_valid  (tin_v),
      .tok_in_pos    (tin_pos),
      .tok_in_value  (tin_val),
      .tok_out_valid (tok_v[k]),
      .tok_out_pos   (tok_pos[k]),
      .tok_out_value (tok_val[k]),
      .up_valid      (up_v[k]),
      .up_pos        (up_pos[k]),
      .up_value      (up_val[k]),
      .settle        (settle[k]),
      .wr_valid      (ld_hit | cw_v),
      .wr_pos        (ld_hit ? tail_pos : cw_pos),
      .wr_value      (ld_hit ? ld_value : cw_val),
      .fetch_valid   ((state == S_FETCH) && (tail_lvl == LW'(k))),
      .fetch_pos     (tail_pos),
      .fetch_value   (fetch_val[k])
    );
  end

  assign sift_done = (|settle) | tok_v[D];

  // tail slot select for the last entry read
  always_comb begin
    fetched = '0;
    for (int k = 1; k <= D; k++) begin
      if (tail_lvl == LW'(k)) begin
        fetched = fetch_val[k];
      end
    end
  end

  // next free slot as level and position, stepped up on load and down on extract
  always_comb begin
    lvl_size      = (PW + 1)'(1) << tail_lvl;
    pos_up        = (PW + 1)'(tail_pos) + (PW + 1)'(1);
    tail_lvl_next = tail_lvl;
    tail_pos_next = tail_pos;
    if (load_en) begin
      if (pos_up == lvl_size) begin
        tail_lvl_next = tail_lvl + LW'(1);
        tail_pos_next = '0;
      end else begin
        tail_pos_next = pos_up[PW-1:0];
      end
    end else if (accept && (request.mode == MODE_EXTRACT) && (count != '0)) begin
      if (tail_pos == '0) begin
        tail_lvl_next = tail_lvl - LW'(1);
        tail_pos_next = PW'(((PW + 1)'(1) << (tail_lvl - LW'(1))) - (PW + 1)'(1));
      end else begin
        tail_pos_next = tail_pos - PW'(1);
      end
    end
  end

  // fill count and tail pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      tail_lvl <= '0;
      tail_pos <= '0;
    end else begin
      tail_lvl <= tail_lvl_next;
      tail_pos <= tail_pos_next;
      if (load_en) begin
        count <= count + CW'(1);
      end else if (accept && (request.mode == MODE_EXTRACT) && (count != '0)) begin
        count <= count - CW'(1);
      end
    end
  end

  // root slot lives in a register
  always_ff @(posedge clk) begin
    if (load_en && (tail_lvl == '0)) begin
      root <= ld_value;
    end else if (up_v[1]) begin
      root <= up_val[1];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: read the last entry, start the token at the root, wait for it to settle
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (request.mode == MODE_EXTRACT) && (count > CW'(1))) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_SIFT;
      end
      S_SIFT: begin
        if (sift_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // token injection into the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      inj_valid <= 1'b0;
    end else begin
      inj_valid <= (state == S_WAIT);
    end
  end

  always_ff @(posedge clk) begin
    inj_value <= fetched;
  end

  // response register, one strobe per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (request.mode == MODE_LOAD) begin
        response.max_value <= '0;
        response.status    <= full ? ST_FULL : ST_LOADED;
      end else if (count == '0) begin
        response.max_value <= '0;
        response.status    <= ST_EMPTY;
      end else begin
        response.max_value <= FIELD_WIDTH'(root);
        response.status    <= ST_EXTRACTED;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("response strobe without an accepted transaction");

  a_settle_in_sift: assert property (@(posedge clk) disable iff (rst)
    sift_done |-> (state == S_SIFT))
    else $error("sift finished outside the sift phase");

  a_single_settle: assert property (@(posedge clk) disable iff (rst)
    $onehot0({settle, tok_v[D]}))
    else $error("more than one level settled at once");

  a_extract_status: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.mode == MODE_EXTRACT) && (count != '0))
      |=> (response.status == ST_EXTRACTED))
    else $error("extract of a non-empty heap not reported as extracted");
`endif

endmodule

@@ hdl/mhe_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mhe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mhe_cell.sv @@
// one heap level: left and right child banks plus one sift-down compare step
`timescale 1ns / 1ps

module mhe_cell #(
  parameter int LEVEL       = 1,
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int PW = CW,
  localparam int VW = VALUE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CW-1:0]        count,
  // token from the level above: value sitting at parent slot tok_in_pos
  input  logic                 tok_in_valid,
  input  logic [PW-1:0]        tok_in_pos,
  input  logic signed [VW-1:0] tok_in_value,
  // token handed to the level below
  output logic                 tok_out_valid,
  output logic [PW-1:0]        tok_out_pos,
  output logic signed [VW-1:0] tok_out_value,
  // write back into the parent slot
  output logic                 up_valid,
  output logic [PW-1:0]        up_pos,
  output logic signed [VW-1:0] up_value,
  output logic                 settle,
  // write into this level
  input  logic                 wr_valid,
  input  logic [PW-1:0]        wr_pos,
  input  logic signed [VW-1:0] wr_value,
  // single slot read of this level
  input  logic                 fetch_valid,
  input  logic [PW-1:0]        fetch_pos,
  output logic signed [VW-1:0] fetch_value
);

  localparam int IW         = CW + 1;
  localparam int BASE       = (1 << LEVEL) - 1;
  localparam int SLOTS_FULL = 1 << LEVEL;
  localparam int SLOTS      = (CAPACITY - BASE < SLOTS_FULL) ? CAPACITY - BASE : SLOTS_FULL;
  localparam int ROWS       = (SLOTS + 1) / 2;
  localparam int AW         = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic                 we_l;
  logic                 we_r;
  logic signed [VW-1:0] rdata_l;
  logic signed [VW-1:0] rdata_r;

  logic                 s1_valid;
  logic [PW-1:0]        s1_pos;
  logic signed [VW-1:0] s1_value;
  logic                 fetch_side;

  logic [IW-1:0]        left_idx;
  logic [IW-1:0]        right_idx;
  logic                 left_ok;
  logic                 right_ok;
  logic                 pick_left;
  logic                 pick_right;
  logic signed [VW-1:0] best_l;
  logic signed [VW-1:0] chosen;

  // bank addressing: row is the parent position, bank is the child side
  assign raddr = tok_in_valid ? tok_in_pos[AW-1:0] : fetch_pos[AW:1];
  assign waddr = wr_pos[AW:1];
  assign we_l  = wr_valid & ~wr_pos[0];
  assign we_r  = wr_valid &  wr_pos[0];

  mhe_ram #(.WIDTH(VW), .DEPTH(ROWS)) u_left (
    .clk   (clk),
    .we    (we_l),
    .waddr (waddr),
    .wdata (wr_value),
    .raddr (raddr),
    .rdata (rdata_l)
  );

  mhe_ram #(.WIDTH(VW), .DEPTH(ROWS)) u_right (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wr_value),
    .raddr (raddr),
    .rdata (rdata_r)
  );

  // token stage aligned with the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos   <= tok_in_pos;
    s1_value <= tok_in_value;
    if (fetch_valid) begin
      fetch_side <= fetch_pos[0];
    end
  end

  assign fetch_value = fetch_side ? rdata_r : rdata_l;

  // pick the largest of parent, left and right; ties keep the earlier one
  always_comb begin
    left_idx   = IW'(BASE) + {s1_pos, 1'b0};
    right_idx  = left_idx + IW'(1);
    left_ok    = left_idx < IW'(count);
    right_ok   = right_idx < IW'(count);
    pick_left  = left_ok && (rdata_l > s1_value);
    best_l     = pick_left ? rdata_l : s1_value;
    pick_right = right_ok && (rdata_r > best_l);
    chosen     = pick_right ? rdata_r : best_l;
  end

  // hand the token down and write the winner into the parent slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
      up_valid      <= 1'b0;
      settle        <= 1'b0;
    end else begin
      tok_out_valid <= s1_valid & (pick_left | pick_right);
      up_valid      <= s1_valid;
      settle        <= s1_valid & ~(pick_left | pick_right);
    end
  end

  always_ff @(posedge clk) begin
    tok_out_pos   <= {s1_pos[PW-2:0], pick_right};
    tok_out_value <= s1_value;
    up_pos        <= s1_pos;
    up_value      <= chosen;
  end

endmodule
